@@ rtl/core/sbc_pkg.sv @@
// Shared types and constants of the slab buffer cache.
package sbc_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COUNT_W = 7;

  localparam logic CMD_TAKE = 1'b0;
  localparam logic CMD_GIVE = 1'b1;

  typedef struct packed {
    logic store_we;
    logic store_re;
    logic pool_we;
    logic pool_re;
  } mem_ctl_t;

endpackage

@@ rtl/core/sbc_mem.sv @@
// Buffer address store and pool slab stack, with the post-reset fill sweep.
module sbc_mem #(
  parameter int unsigned SLAB_BUFFERS = 64,
  parameter int unsigned POOL_SLABS   = 16,
  parameter int unsigned BUF_BYTES    = 2048,
  localparam int unsigned STORE_DEPTH = (POOL_SLABS + 2) * SLAB_BUFFERS,
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH),
  localparam int unsigned SLAB_W      = $clog2(POOL_SLABS + 2),
  localparam int unsigned PL_AW       = $clog2(POOL_SLABS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sbc_pkg::mem_ctl_t         ctl_i,
  input  logic [IDX_W-1:0]          st_waddr_i,
  input  logic [sbc_pkg::ADDR_W-1:0] st_wdata_i,
  input  logic [IDX_W-1:0]          st_raddr_i,
  output logic [sbc_pkg::ADDR_W-1:0] st_rdata_o,
  input  logic [PL_AW-1:0]          pl_waddr_i,
  input  logic [SLAB_W-1:0]         pl_wdata_i,
  input  logic [PL_AW-1:0]          pl_raddr_i,
  output logic [SLAB_W-1:0]         pl_rdata_o,
  output logic                      init_done_o
);
  import sbc_pkg::*;

  logic [ADDR_W-1:0] store_mem [STORE_DEPTH];
  logic [SLAB_W-1:0] pool_mem  [POOL_SLABS];

  logic              init_busy_q, init_busy_d;
  logic [IDX_W-1:0]  init_idx_q, init_idx_d;
  logic [ADDR_W-1:0] init_val_q, init_val_d;

  logic              st_we;
  logic [IDX_W-1:0]  st_waddr;
  logic [ADDR_W-1:0] st_wdata;
  logic              pl_we;
  logic [PL_AW-1:0]  pl_waddr;
  logic [SLAB_W-1:0] pl_wdata;

  always_comb begin
    init_busy_d = init_busy_q;
    init_idx_d  = init_idx_q;
    init_val_d  = init_val_q;
    if (init_busy_q) begin
      init_idx_d = init_idx_q + IDX_W'(1);
      init_val_d = init_val_q + ADDR_W'(BUF_BYTES);
      if (init_idx_q == IDX_W'(STORE_DEPTH - 1)) begin
        init_busy_d = 1'b0;
      end
    end
  end

  always_comb begin
    if (init_busy_q) begin
      st_we    = 1'b1;
      st_waddr = init_idx_q;
      st_wdata = init_val_q;
      pl_we    = (init_idx_q < IDX_W'(POOL_SLABS));
      pl_waddr = init_idx_q[PL_AW-1:0];
      pl_wdata = SLAB_W'(init_idx_q);
    end else begin
      st_we    = ctl_i.store_we;
      st_waddr = st_waddr_i;
      st_wdata = st_wdata_i;
      pl_we    = ctl_i.pool_we;
      pl_waddr = pl_waddr_i;
      pl_wdata = pl_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_busy_q <= 1'b1;
      init_idx_q  <= '0;
      init_val_q  <= '0;
    end else begin
      init_busy_q <= init_busy_d;
      init_idx_q  <= init_idx_d;
      init_val_q  <= init_val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    if (ctl_i.store_re) begin
      st_rdata_o <= store_mem[st_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pl_we) begin
      pool_mem[pl_waddr] <= pl_wdata;
    end
    if (ctl_i.pool_re) begin
      pl_rdata_o <= pool_mem[pl_raddr_i];
    end
  end

  assign init_done_o = !init_busy_q;

endmodule

@@ rtl/core/slab_buffer_cache_top.sv @@
// Slab buffer cache: take and give sequencer around the address store and pool stack.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------------
//  in      | in_valid_i / in_stall_o | command_i, count_i, returned_address_i
//  out     | out_valid_o / out_stall_i | handed_address_o, granted_o, last_o, give_error_o
//
// A take swaps in a full slab (pool read, TSWAP) when its slab is empty, then in TCALC and
// TEMIT gives up to MAX_BURST results, one per cycle while out_stall_i is low, each from
// one store read. A give writes the store from IDLE; when its slab is full it reads the
// pool and writes in GSWAP, or flags give_error_o if the pool is full; it answers in RESP.
// After reset a fill sweep over the (POOL_SLABS + 2) * SLAB_BUFFERS store entries (1152 at
// the defaults) loads the store and the pool; in_stall_o stays high. A stalled result holds
// the sequencer; a new item is taken while the last result waits in the output register.
module slab_buffer_cache_top #(
  parameter int unsigned SLAB_BUFFERS = 64,
  parameter int unsigned POOL_SLABS   = 16,
  parameter int unsigned BUF_BYTES    = 2048,
  parameter int unsigned MAX_BURST    = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        command_i,
  input  logic [sbc_pkg::COUNT_W-1:0] count_i,
  input  logic [sbc_pkg::ADDR_W-1:0]  returned_address_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sbc_pkg::ADDR_W-1:0]  handed_address_o,
  output logic                        granted_o,
  output logic                        last_o,
  output logic                        give_error_o
);
  import sbc_pkg::*;

  localparam int unsigned STORE_DEPTH = (POOL_SLABS + 2) * SLAB_BUFFERS;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
  localparam int unsigned SLAB_W      = $clog2(POOL_SLABS + 2);
  localparam int unsigned PL_AW       = $clog2(POOL_SLABS);
  localparam int unsigned FC_W        = $clog2(POOL_SLABS + 1);
  localparam int unsigned CNT_W       = $clog2(SLAB_BUFFERS + 1);
  localparam int unsigned SLOT_W      = $clog2(SLAB_BUFFERS);
  localparam int unsigned MW          = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_TSWAP = 3'd2;
  localparam logic [2:0] ST_TCALC = 3'd3;
  localparam logic [2:0] ST_TEMIT = 3'd4;
  localparam logic [2:0] ST_GSWAP = 3'd5;
  localparam logic [2:0] ST_RESP  = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [FC_W-1:0]    full_count_q, full_count_d;
  logic [SLAB_W-1:0]  take_slab_q, take_slab_d;
  logic [CNT_W-1:0]   take_count_q, take_count_d;
  logic [SLAB_W-1:0]  give_slab_q, give_slab_d;
  logic [CNT_W-1:0]   give_count_q, give_count_d;
  logic [COUNT_W-1:0] req_count_q, req_count_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic [ADDR_W-1:0]  hold_addr_q, hold_addr_d;
  logic               resp_err_q, resp_err_d;

  logic               out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]  out_addr_q, out_addr_d;
  logic               out_granted_q, out_granted_d;
  logic               out_last_q, out_last_d;
  logic               out_err_q, out_err_d;
  logic               out_free;

  mem_ctl_t           mem_ctl;
  logic [IDX_W-1:0]   st_waddr, st_raddr;
  logic [ADDR_W-1:0]  st_wdata, st_rdata;
  logic [PL_AW-1:0]   pl_waddr, pl_raddr;
  logic [SLAB_W-1:0]  pl_wdata, pl_rdata;
  logic               init_done;

  logic [CNT_W-1:0]   take_dec;
  logic [FC_W-1:0]    full_dec;
  logic [IDX_W-1:0]   take_idx, give_idx, swap_idx;
  logic [MW-1:0]      grant_a, grant_n;

  assign take_dec = take_count_q - CNT_W'(1);
  assign full_dec = full_count_q - FC_W'(1);
  assign take_idx = IDX_W'(take_slab_q) * IDX_W'(SLAB_BUFFERS) + IDX_W'(take_dec[SLOT_W-1:0]);
  assign give_idx = IDX_W'(give_slab_q) * IDX_W'(SLAB_BUFFERS)
                    + IDX_W'(give_count_q[SLOT_W-1:0]);
  assign swap_idx = IDX_W'(pl_rdata) * IDX_W'(SLAB_BUFFERS);

  assign grant_a = (MW'(req_count_q) < MW'(take_count_q)) ? MW'(req_count_q)
                                                          : MW'(take_count_q);
  assign grant_n = (grant_a < MW'(MAX_BURST)) ? grant_a : MW'(MAX_BURST);

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    full_count_d  = full_count_q;
    take_slab_d   = take_slab_q;
    take_count_d  = take_count_q;
    give_slab_d   = give_slab_q;
    give_count_d  = give_count_q;
    req_count_d   = req_count_q;
    rem_d         = rem_q;
    hold_addr_d   = hold_addr_q;
    resp_err_d    = resp_err_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_addr_d    = out_addr_q;
    out_granted_d = out_granted_q;
    out_last_d    = out_last_q;
    out_err_d     = out_err_q;
    mem_ctl       = '0;
    st_waddr      = give_idx;
    st_wdata      = returned_address_i;
    st_raddr      = take_idx;
    pl_waddr      = full_dec[PL_AW-1:0];
    pl_wdata      = take_slab_q;
    pl_raddr      = full_dec[PL_AW-1:0];

    case (state_q)
      ST_INIT: begin
        if (init_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (command_i == CMD_TAKE) begin
            req_count_d = count_i;
            if (take_count_q == '0 && full_count_q != '0) begin
              mem_ctl.pool_re = 1'b1;
              state_d         = ST_TSWAP;
            end else begin
              state_d = ST_TCALC;
            end
          end else if (give_count_q < CNT_W'(SLAB_BUFFERS)) begin
            mem_ctl.store_we = 1'b1;
            give_count_d     = give_count_q + CNT_W'(1);
            resp_err_d       = 1'b0;
            state_d          = ST_RESP;
          end else if (full_count_q >= FC_W'(POOL_SLABS)) begin
            resp_err_d = 1'b1;
            state_d    = ST_RESP;
          end else begin
            hold_addr_d     = returned_address_i;
            mem_ctl.pool_re = 1'b1;
            pl_raddr        = full_count_q[PL_AW-1:0];
            state_d         = ST_GSWAP;
          end
        end
      end
      ST_TSWAP: begin
        mem_ctl.pool_we = 1'b1;
        full_count_d    = full_dec;
        take_slab_d     = pl_rdata;
        take_count_d    = CNT_W'(SLAB_BUFFERS);
        state_d         = ST_TCALC;
      end
      ST_TCALC: begin
        if (grant_n == '0) begin
          resp_err_d = 1'b0;
          state_d    = ST_RESP;
        end else begin
          mem_ctl.store_re = 1'b1;
          take_count_d     = take_dec;
          rem_d            = COUNT_W'(grant_n);
          state_d          = ST_TEMIT;
        end
      end
      ST_TEMIT: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_addr_d    = st_rdata;
          out_granted_d = 1'b1;
          out_last_d    = (rem_q == COUNT_W'(1));
          out_err_d     = 1'b0;
          if (rem_q != COUNT_W'(1)) begin
            mem_ctl.store_re = 1'b1;
            take_count_d     = take_dec;
            rem_d            = rem_q - COUNT_W'(1);
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_GSWAP: begin
        mem_ctl.pool_we  = 1'b1;
        pl_waddr         = full_count_q[PL_AW-1:0];
        pl_wdata         = give_slab_q;
        full_count_d     = full_count_q + FC_W'(1);
        mem_ctl.store_we = 1'b1;
        st_waddr         = swap_idx;
        st_wdata         = hold_addr_q;
        give_slab_d      = pl_rdata;
        give_count_d     = CNT_W'(1);
        resp_err_d       = 1'b0;
        state_d          = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_addr_d    = '0;
          out_granted_d = 1'b0;
          out_last_d    = 1'b1;
          out_err_d     = resp_err_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      full_count_q <= FC_W'(POOL_SLABS);
      take_slab_q  <= SLAB_W'(POOL_SLABS);
      take_count_q <= '0;
      give_slab_q  <= SLAB_W'(POOL_SLABS + 1);
      give_count_q <= '0;
      rem_q        <= '0;
      resp_err_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      full_count_q <= full_count_d;
      take_slab_q  <= take_slab_d;
      take_count_q <= take_count_d;
      give_slab_q  <= give_slab_d;
      give_count_q <= give_count_d;
      rem_q        <= rem_d;
      resp_err_q   <= resp_err_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_count_q   <= req_count_d;
    hold_addr_q   <= hold_addr_d;
    out_addr_q    <= out_addr_d;
    out_granted_q <= out_granted_d;
    out_last_q    <= out_last_d;
    out_err_q     <= out_err_d;
  end

  sbc_mem #(
    .SLAB_BUFFERS (SLAB_BUFFERS),
    .POOL_SLABS   (POOL_SLABS),
    .BUF_BYTES    (BUF_BYTES)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (mem_ctl),
    .st_waddr_i  (st_waddr),
    .st_wdata_i  (st_wdata),
    .st_raddr_i  (st_raddr),
    .st_rdata_o  (st_rdata),
    .pl_waddr_i  (pl_waddr),
    .pl_wdata_i  (pl_wdata),
    .pl_raddr_i  (pl_raddr),
    .pl_rdata_o  (pl_rdata),
    .init_done_o (init_done)
  );

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign handed_address_o = out_addr_q;
  assign granted_o        = out_granted_q;
  assign last_o           = out_last_q;
  assign give_error_o     = out_err_q;

  a_full_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_count_q <= FC_W'(POOL_SLABS))
    else $error("pool full count beyond pool size");

  a_slab_counts_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_count_q <= CNT_W'(SLAB_BUFFERS) && give_count_q <= CNT_W'(SLAB_BUFFERS))
    else $error("slab fill count beyond slab size");

  a_emit_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TEMIT |-> rem_q != '0 && rem_q <= COUNT_W'(MAX_BURST))
    else $error("burst counter out of range while emitting");

  a_store_port_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl.store_re && mem_ctl.store_we) && !(mem_ctl.pool_re && mem_ctl.pool_we))
    else $error("read and write to one memory in the same cycle");

  a_take_emit_granted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TEMIT && out_free) |=> out_valid_q && out_granted_q)
    else $error("take burst result lost");

endmodule

@@ bench/sbc_checker.sv @@
`timescale 1ns / 100ps
// Watches both channels of the slab buffer cache, predicts every result and compares it.
module sbc_checker import sbc_pkg::*; #(
  parameter int unsigned SLAB_BUFFERS = 64,
  parameter int unsigned POOL_SLABS   = 16,
  parameter int unsigned BUF_BYTES    = 2048,
  parameter int unsigned MAX_BURST    = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               command_i,
  input  logic [COUNT_W-1:0] count_i,
  input  logic [ADDR_W-1:0]  returned_address_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [ADDR_W-1:0]  handed_address_i,
  input  logic               granted_i,
  input  logic               last_i,
  input  logic               give_error_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        result_count_o,
  output int unsigned        give_error_count_o,
  output int unsigned        dry_take_count_o
);

  localparam int unsigned STORE_DEPTH = (POOL_SLABS + 2) * SLAB_BUFFERS;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              granted;
    logic              last;
    logic              give_error;
  } handout_t;

  logic [ADDR_W-1:0] addr_store [STORE_DEPTH];
  int unsigned       slab_stack [POOL_SLABS];
  int unsigned       full_slabs;
  int unsigned       take_slab;
  int unsigned       take_left;
  int unsigned       give_slab;
  int unsigned       give_fill;
  handout_t          pending_handouts [$];

  task automatic clear_pool();
    int unsigned k;
    for (k = 0; k < STORE_DEPTH; k++) begin
      addr_store[k] = ADDR_W'(k * BUF_BYTES);
    end
    for (k = 0; k < POOL_SLABS; k++) begin
      slab_stack[k] = k;
    end
    full_slabs = POOL_SLABS;
    take_slab  = POOL_SLABS;
    take_left  = 0;
    give_slab  = POOL_SLABS + 1;
    give_fill  = 0;
    pending_handouts.delete();
  endtask

  task automatic grant_buffers(input logic [COUNT_W-1:0] asked);
    int unsigned grant;
    int unsigned spare;
    int unsigned k;
    handout_t    r;
    if (take_left == 0 && full_slabs > 0) begin
      full_slabs             = full_slabs - 1;
      spare                  = slab_stack[full_slabs];
      slab_stack[full_slabs] = take_slab;
      take_slab              = spare;
      take_left              = SLAB_BUFFERS;
    end
    grant = asked;
    if (grant > take_left) grant = take_left;
    if (grant > MAX_BURST) grant = MAX_BURST;
    if (grant == 0) begin
      r = '{addr: '0, granted: 1'b0, last: 1'b1, give_error: 1'b0};
      pending_handouts.push_back(r);
      dry_take_count_o++;
    end else begin
      for (k = 0; k < grant; k++) begin
        take_left = take_left - 1;
        r = '{addr: addr_store[take_slab * SLAB_BUFFERS + take_left], granted: 1'b1,
              last: (k + 1 == grant), give_error: 1'b0};
        pending_handouts.push_back(r);
      end
    end
  endtask

  task automatic return_buffer(input logic [ADDR_W-1:0] addr);
    int unsigned spare;
    handout_t    r;
    r = '{addr: '0, granted: 1'b0, last: 1'b1, give_error: 1'b0};
    if (give_fill < SLAB_BUFFERS) begin
      addr_store[give_slab * SLAB_BUFFERS + give_fill] = addr;
      give_fill = give_fill + 1;
    end else if (full_slabs >= POOL_SLABS) begin
      r.give_error = 1'b1;
      give_error_count_o++;
    end else begin
      spare                           = slab_stack[full_slabs];
      slab_stack[full_slabs]          = give_slab;
      full_slabs                      = full_slabs + 1;
      addr_store[spare * SLAB_BUFFERS] = addr;
      give_slab                       = spare;
      give_fill                       = 1;
    end
    pending_handouts.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: result %0d %s expected %h actual %h", $time, result_count_o, name,
               want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    handout_t want;
    if (!rst_ni) begin
      clear_pool();
      fail_count_o       = 0;
      result_count_o     = 0;
      give_error_count_o = 0;
      dry_take_count_o   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_handouts.size() == 0) begin
          $display({"%0t: unexpected result, expected none, ",
                    "actual addr %h granted %b last %b error %b"},
                   $time, handed_address_i, granted_i, last_i, give_error_i);
          fail_count_o++;
        end else begin
          want = pending_handouts.pop_front();
          check_field("handed_address", want.addr, handed_address_i);
          check_field("granted", ADDR_W'(want.granted), ADDR_W'(granted_i));
          check_field("last", ADDR_W'(want.last), ADDR_W'(last_i));
          check_field("give_error", ADDR_W'(want.give_error), ADDR_W'(give_error_i));
        end
        result_count_o++;
      end
      if (in_valid_i && !in_stall_i) begin
        if (command_i == CMD_TAKE) begin
          grant_buffers(count_i);
        end else begin
          return_buffer(returned_address_i);
        end
      end
    end
    pending_o = pending_handouts.size();
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Stimulus, idling, watchdog and verdict for the slab buffer cache.
module tb;
  import sbc_pkg::*;

  localparam int unsigned PHASE1_ITEMS    = 100;
  localparam int unsigned PHASE2_ITEMS    = 100;
  localparam int unsigned PHASE3_ITEMS    = 110;
  localparam int unsigned DRAIN_TAKES     = 18;
  localparam int unsigned FILL_GIVES      = 61;
  localparam int unsigned PRESSURE_AT     = 360;
  localparam int unsigned HOLD_CYCLES     = 600;
  localparam int unsigned WATCHDOG_CYCLES = 5000;
  localparam int unsigned SETTLE_CYCLES   = 200;

  typedef enum int unsigned {SEG_GIVES, SEG_TAKES, SEG_MIXED} segment_e;

  logic               clk_i              = 1'b0;
  logic               rst_ni             = 1'b0;
  logic               in_valid_i         = 1'b0;
  logic               command_i          = CMD_TAKE;
  logic [COUNT_W-1:0] count_i            = '0;
  logic [ADDR_W-1:0]  returned_address_i = '0;
  logic               out_stall_i        = 1'b0;
  logic               hold_off           = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [ADDR_W-1:0]  handed_address_o;
  logic               granted_o;
  logic               last_o;
  logic               give_error_o;

  int unsigned send_idle_pct = 31;
  int unsigned stall_pct     = 81;
  int unsigned items_sent    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned result_count;
  int unsigned give_error_count;
  int unsigned dry_take_count;

  slab_buffer_cache_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .count_i            (count_i),
    .returned_address_i (returned_address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .handed_address_o   (handed_address_o),
    .granted_o          (granted_o),
    .last_o             (last_o),
    .give_error_o       (give_error_o)
  );

  sbc_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .command_i          (command_i),
    .count_i            (count_i),
    .returned_address_i (returned_address_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .handed_address_i   (handed_address_o),
    .granted_i          (granted_o),
    .last_i             (last_o),
    .give_error_i       (give_error_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .result_count_o     (result_count),
    .give_error_count_o (give_error_count),
    .dry_take_count_o   (dry_take_count)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // hold off the receiver while items keep coming, so the block backs up
  initial begin
    wait (items_sent >= PRESSURE_AT);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  task automatic send_item(input logic cmd, input logic [COUNT_W-1:0] cnt,
                           input logic [ADDR_W-1:0] addr);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i         <= 1'b1;
    command_i          <= cmd;
    count_i            <= cnt;
    returned_address_i <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_give(input logic [ADDR_W-1:0] addr);
    send_item(CMD_GIVE, COUNT_W'($urandom_range(127)), addr);
  endtask

  task automatic send_take(input logic [COUNT_W-1:0] cnt);
    send_item(CMD_TAKE, cnt, $urandom);
  endtask

  task automatic run_phase(input int unsigned n);
    int unsigned sent;
    int unsigned len;
    int unsigned k;
    segment_e    seg;
    sent = 0;
    while (sent < n) begin
      k = $urandom_range(99);
      seg = (k < 35) ? SEG_GIVES : (k < 75) ? SEG_TAKES : SEG_MIXED;
      case (seg)
        SEG_GIVES: len = $urandom_range(70, 8);
        SEG_TAKES: len = $urandom_range(10, 2);
        default:   len = $urandom_range(12, 3);
      endcase
      for (k = 0; k < len && sent < n; k++) begin
        case (seg)
          SEG_GIVES: send_give($urandom);
          SEG_TAKES: begin
            if ($urandom_range(3) == 0) begin
              send_take(COUNT_W'($urandom_range(127, 64)));
            end else begin
              send_take(COUNT_W'($urandom_range(127)));
            end
          end
          default: send_item(1'($urandom_range(1)), COUNT_W'($urandom_range(127)), $urandom);
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned k;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_give('0);
    send_give('1);
    send_give(32'h8000_0001);
    for (k = 0; k < FILL_GIVES; k++) begin
      send_give($urandom);
    end
    send_give(32'h5A5A_A5A5);
    send_give(32'hA5A5_5A5A);
    send_take('0);
    send_take(COUNT_W'(1));
    send_take('1);
    send_take(COUNT_W'(64));
    send_take('0);
    send_take(COUNT_W'(2));

    repeat (DRAIN_TAKES) send_take(COUNT_W'($urandom_range(127, 64)));
    run_phase(PHASE1_ITEMS);

    send_idle_pct = 81;
    stall_pct     = 31;
    run_phase(PHASE2_ITEMS);

    send_idle_pct = 0;
    stall_pct     = 0;
    run_phase(PHASE3_ITEMS);
    in_valid_i <= 1'b0;

    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d items and %0d results: %0d give errors, %0d takes with no grant,",
             items_sent, result_count, give_error_count, dry_take_count);
    $display("pool exhausted and refilled, receiver held off for %0d cycles", HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
